// ===== hdl/dtsma_pkg.sv =====
`default_nettype none

package dtsma_pkg;

   // drive sample and mean width
   localparam int SAMPLE_W = 8;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

endpackage

`default_nettype wire

// ===== hdl/dtsma_ring.sv =====
`default_nettype none

module dtsma_ring
   import dtsma_pkg::*;
#(
   parameter int DEPTH = 8,
   localparam int SUM_W = $clog2(DEPTH) + SAMPLE_W
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire sample_type              din,
   output logic signed [SUM_W-1:0]      sum_ff
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   sample_type mem [DEPTH];

   logic [AW-1:0]            pos_ff, pos_in, next_pos;
   logic                     full_ff, full_in;
   logic                     rd_ok_ff, rd_ok_in;
   sample_type               rd_ff;
   sample_type               last_ff;
   sample_type               oldest;
   logic signed [SUM_W-1:0]  sum_in;
   logic                     wrap;

   // circular write position
   always_comb begin
      wrap     = (pos_ff == AW'(DEPTH - 1));
      next_pos = wrap ? '0 : pos_ff + AW'(1);
   end

   // entry about to be overwritten, zero until the store has filled once
   always_comb begin
      if (DEPTH == 1) begin
         oldest = last_ff;
      end else if (rd_ok_ff) begin
         oldest = rd_ff;
      end else begin
         oldest = '0;
      end
   end

   // running sum and fill tracking
   always_comb begin
      pos_in   = pos_ff;
      full_in  = full_ff;
      rd_ok_in = rd_ok_ff;
      sum_in   = sum_ff;
      if (push) begin
         pos_in   = next_pos;
         full_in  = full_ff | wrap;
         rd_ok_in = full_ff | wrap;
         sum_in   = sum_ff + SUM_W'(din) - SUM_W'(oldest);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         full_ff  <= 1'b0;
         rd_ok_ff <= 1'b0;
         sum_ff   <= '0;
         last_ff  <= '0;
      end else begin
         pos_ff   <= pos_in;
         full_ff  <= full_in;
         rd_ok_ff <= rd_ok_in;
         sum_ff   <= sum_in;
         if (push) begin
            last_ff <= din;
         end
      end
   end

   // sample store, read ahead of the next push
   always_ff @(posedge clock) begin
      if (push) begin
         mem[pos_ff] <= din;
         rd_ff       <= mem[next_pos];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/dtsma_div.sv =====
`default_nettype none

module dtsma_div
   import dtsma_pkg::*;
#(
   parameter int DIVISOR = 8,
   parameter int X_W = 11
) (
   input  wire logic                   clock,
   input  wire logic                   enable,
   input  wire logic signed [X_W-1:0]  x,
   output sample_type                  q
);

   // reciprocal exact for every magnitude below 2**X_W
   localparam int L     = $clog2(DIVISOR);
   localparam int SHIFT = X_W + L;
   localparam int MW    = X_W + 2;
   localparam int PW    = X_W + MW;
   localparam logic [MW-1:0] RECIP = MW'(((2 ** SHIFT) + DIVISOR - 1) / DIVISOR);

   logic [X_W-1:0]      mag;
   logic [PW-1:0]       prod_ff, prod_in;
   logic                neg_ff;
   logic [PW-1:0]       shifted;
   logic [SAMPLE_W-1:0] mag_q;

   // magnitude times reciprocal
   always_comb begin
      mag     = x[X_W-1] ? X_W'(-x) : X_W'(x);
      prod_in = PW'(mag) * PW'(RECIP);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
         neg_ff  <= x[X_W-1];
      end
   end

   // quotient with sign restored, truncated toward zero
   always_comb begin
      shifted = prod_ff >> SHIFT;
      mag_q   = shifted[SAMPLE_W-1:0];
      q       = neg_ff ? sample_type'(-mag_q) : sample_type'(mag_q);
   end

endmodule

`default_nettype wire

// ===== hdl/decimated_two_stage_moving_average.sv =====
// Decimated two-stage moving average.
// Input channel req_*: one signed 8-bit drive sample per beat. Result channel
// rsp_*: one beat per input beat, carrying the sample itself, the mean of the
// last MEAN_COUNT window means, and in tuser a flag set when this beat took a
// new window mean (the first beat after reset and every DECIMATION-th after).
// Throughput: one beat per cycle while the result channel is not stalled.
// Path: each accepted beat passes these registered steps: window sum update,
// reciprocal multiply, history sum update, reciprocal multiply, result.
// Each divide by WINDOW_LEN or MEAN_COUNT is a multiply by a constant
// reciprocal with a register after it.
// Reset (synchronous, active high) empties the pipeline and makes both
// circular stores read as zero until overwritten; the decimation phase
// restarts. No clearing pass is needed, an item may be sent right after reset.
// When the receiver holds rsp_tready low with a result pending, the whole
// pipeline holds and req_tready drops; up to five beats sit in flight.
`default_nettype none

module decimated_two_stage_moving_average
   import dtsma_pkg::*;
#(
   parameter int WINDOW_LEN = 8,
   parameter int MEAN_COUNT = 8,
   parameter int DECIMATION = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] sample
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] latest_sample, [15:8] overall_mean
   output logic             rsp_tuser    // [0] mean_taken
);

   localparam int PH_W  = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
   localparam int WSUM_W = $clog2(WINDOW_LEN) + SAMPLE_W;
   localparam int HSUM_W = $clog2(MEAN_COUNT) + SAMPLE_W;

   typedef struct packed {
      logic       valid;
      logic       take;
      sample_type sample;
   } stage_type;

   logic                     adv;
   logic                     accept;
   logic                     take_now;
   logic [PH_W-1:0]          phase_ff, phase_in;
   stage_type                s1_ff, s2_ff, s3_ff, s4_ff, out_ff;
   stage_type                s1_in;
   sample_type               mean_out_ff;
   logic signed [WSUM_W-1:0] window_sum;
   logic signed [HSUM_W-1:0] history_sum;
   sample_type               window_mean;
   sample_type               overall_mean;
   logic                     hist_push;

   // pipeline moves whenever the result register is free or being taken
   assign adv        = ~out_ff.valid | rsp_tready;
   assign req_tready = adv;
   assign accept     = req_tvalid & adv;

   // decimation phase
   always_comb begin
      take_now = (phase_ff == '0);
      phase_in = phase_ff;
      if (accept) begin
         phase_in = (phase_ff == PH_W'(DECIMATION - 1)) ? '0 : phase_ff + PH_W'(1);
      end
      s1_in.valid  = accept;
      s1_in.take   = take_now;
      s1_in.sample = sample_type'(req_tdata);
   end

   // sample window with running sum
   dtsma_ring #(
      .DEPTH (WINDOW_LEN)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .push   (accept),
      .din    (sample_type'(req_tdata)),
      .sum_ff (window_sum)
   );

   // window mean
   dtsma_div #(
      .DIVISOR (WINDOW_LEN),
      .X_W     (WSUM_W)
   ) u_window_div (
      .clock  (clock),
      .enable (adv),
      .x      (window_sum),
      .q      (window_mean)
   );

   assign hist_push = adv & s2_ff.valid & s2_ff.take;

   // history of window means with running sum
   dtsma_ring #(
      .DEPTH (MEAN_COUNT)
   ) u_history (
      .clock  (clock),
      .reset  (reset),
      .push   (hist_push),
      .din    (window_mean),
      .sum_ff (history_sum)
   );

   // mean of the stored means
   dtsma_div #(
      .DIVISOR (MEAN_COUNT),
      .X_W     (HSUM_W)
   ) u_history_div (
      .clock  (clock),
      .enable (adv),
      .x      (history_sum),
      .q      (overall_mean)
   );

   // stage registers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         s1_ff    <= '0;
         s2_ff    <= '0;
         s3_ff    <= '0;
         s4_ff    <= '0;
         out_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         if (adv) begin
            s1_ff  <= s1_in;
            s2_ff  <= s1_ff;
            s3_ff  <= s2_ff;
            s4_ff  <= s3_ff;
            out_ff <= s4_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mean_out_ff <= overall_mean;
      end
   end

   assign rsp_tvalid = out_ff.valid;
   assign rsp_tdata  = {mean_out_ff, out_ff.sample};
   assign rsp_tuser  = out_ff.take;

endmodule

`default_nettype wire
